// File: rtl/core/jmf_pkg.sv
// shared types and constants for the json message framer
// no dependencies
package jmf_pkg;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_LSQUARE  = 8'h5B;
    localparam logic [7:0] CH_RSQUARE  = 8'h5D;
    localparam logic [7:0] CH_LCURLY   = 8'h7B;
    localparam logic [7:0] CH_RCURLY   = 8'h7D;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       msg_first;
        logic       msg_last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

endpackage

// File: rtl/core/jmf_if.sv
// valid/ready channel interfaces for the framer input and output items
// no dependencies
interface jmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_last;

    modport source (output valid, output in_byte, output chunk_last, input ready);
    modport sink   (input valid, input in_byte, input chunk_last, output ready);
endinterface

interface jmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       msg_first;
    logic       msg_last;

    modport source (output valid, output out_byte, output msg_first, output msg_last,
                    input ready);
    modport sink   (input valid, input out_byte, input msg_first, input msg_last,
                    output ready);
endinterface

// File: rtl/core/jmf_front.sv
// front end: accepts stream bytes, tracks message framing state, emits items
// depends on jmf_pkg and jmf_in_if
module jmf_front #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jmf_in_if.sink        i_in,
    input  jmf_pkg::t_qstat i_qstat,
    output logic          o_push,
    output jmf_pkg::t_item o_item
);
    import jmf_pkg::*;

    logic                   r_in_message, n_in_message;
    logic                   r_brace_kind, n_brace_kind;
    logic [LEVEL_WIDTH-1:0] r_level, n_level;
    logic                   r_in_quote, n_in_quote;
    logic                   r_escape, n_escape;
    logic                   r_dropping, n_dropping;

    logic       w_accept;
    logic [7:0] w_byte;
    logic [7:0] w_opener;
    logic [7:0] w_closer;

    assign i_in.ready = !i_qstat.full;
    assign w_accept   = i_in.valid && !i_qstat.full;
    assign w_byte     = i_in.in_byte;
    assign w_opener   = r_brace_kind ? CH_LCURLY : CH_LSQUARE;
    assign w_closer   = r_brace_kind ? CH_RCURLY : CH_RSQUARE;

    always_comb begin
        n_in_message = r_in_message;
        n_brace_kind = r_brace_kind;
        n_level      = r_level;
        n_in_quote   = r_in_quote;
        n_escape     = r_escape;
        n_dropping   = r_dropping;
        o_push       = 1'b0;
        o_item       = '{out_byte: w_byte, msg_first: 1'b0, msg_last: 1'b0};
        if (w_accept) begin
            if (!r_in_message) begin
                if (r_dropping) begin
                    if (i_in.chunk_last) begin
                        n_dropping = 1'b0;
                    end
                end else if (is_space(w_byte)) begin
                    n_dropping = 1'b0;
                end else if (w_byte == CH_LSQUARE || w_byte == CH_LCURLY) begin
                    n_in_message     = 1'b1;
                    n_brace_kind     = (w_byte == CH_LCURLY);
                    n_level          = LEVEL_WIDTH'(1);
                    n_in_quote       = 1'b0;
                    n_escape         = 1'b0;
                    o_push           = 1'b1;
                    o_item.msg_first = 1'b1;
                end else begin
                    n_dropping = !i_in.chunk_last;
                end
            end else begin
                o_push = 1'b1;
                if (r_escape) begin
                    n_escape = 1'b0;
                end else if (w_byte == CH_BSLASH && r_in_quote) begin
                    n_escape = 1'b1;
                end else if (w_byte == CH_QUOTE) begin
                    n_in_quote = !r_in_quote;
                end else if (!r_in_quote) begin
                    if (w_byte == w_opener) begin
                        if (r_level != '1) begin
                            n_level = r_level + LEVEL_WIDTH'(1);
                        end
                    end else if (w_byte == w_closer) begin
                        if (r_level != '0) begin
                            n_level = r_level - LEVEL_WIDTH'(1);
                        end
                        if (n_level == '0) begin
                            o_item.msg_last = 1'b1;
                            n_in_message    = 1'b0;
                            n_in_quote      = 1'b0;
                            n_escape        = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_message <= 1'b0;
            r_brace_kind <= 1'b0;
            r_level      <= '0;
            r_in_quote   <= 1'b0;
            r_escape     <= 1'b0;
            r_dropping   <= 1'b0;
        end else begin
            r_in_message <= n_in_message;
            r_brace_kind <= n_brace_kind;
            r_level      <= n_level;
            r_in_quote   <= n_in_quote;
            r_escape     <= n_escape;
            r_dropping   <= n_dropping;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_message |-> (!r_in_quote && !r_escape))
        else $error("string state left set outside a message");
    a_level_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_message |-> (r_level != '0))
        else $error("open message with zero nesting level");
    a_drop_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> !r_in_message)
        else $error("discarding while inside a message");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.msg_last) |=> !r_in_message)
        else $error("message end item without leaving the message");
`endif

endmodule

// File: rtl/core/jmf_fifo.sv
// short item queue between the framing front end and the output stage
// depends on jmf_pkg
module jmf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jmf_pkg::t_item  i_item,
    input  logic            i_pop,
    output jmf_pkg::t_item  o_item,
    output jmf_pkg::t_qstat o_qstat
);
    import jmf_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_item        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/jmf_back.sv
// back end: drains the item queue into the registered output channel
// depends on jmf_pkg and jmf_out_if
module jmf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jmf_pkg::t_item  i_item,
    input  jmf_pkg::t_qstat i_qstat,
    output logic            o_pop,
    jmf_out_if.source       o_out
);
    import jmf_pkg::*;

    logic  r_valid;
    t_item r_data;

    assign o_pop = !i_qstat.empty && (!r_valid || o_out.ready);

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_data.out_byte;
    assign o_out.msg_first = r_data.msg_first;
    assign o_out.msg_last  = r_data.msg_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/core/json_message_framer_top.sv
// json message framer top level: front end, item queue, output stage
// depends on jmf_pkg, jmf_if, jmf_front, jmf_fifo, jmf_back
// path: an accepted byte's item is written into the queue, then into the output register
// throughput: one byte per cycle; input ready drops only when the 4-entry queue is full
// reset: synchronous active low, clears framing state, queue pointers and output valid
module json_message_framer_top #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jmf_in_if.sink    i_in,
    jmf_out_if.source o_out
);
    import jmf_pkg::*;

    logic   w_push;
    logic   w_pop;
    t_item  w_push_item;
    t_item  w_head_item;
    t_qstat w_qstat;

    jmf_front #(
        .LEVEL_WIDTH(LEVEL_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    jmf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_qstat (w_qstat)
    );

    jmf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_head_item),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
